// ===== rtl/core/rgbdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB decimal triplet parser package
// Status codes, character constants and byte classes shared by the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbdtp_pkg;

	// Result status of one finished line.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_VALUE  = 2'd1,
		ST_FORMAT = 2'd2,
		ST_DUP    = 2'd3
	} status_t;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Largest value a color component may take.
	localparam logic [8:0] COMP_MAX = 9'd255;
	// Saturation point of the digit accumulator.
	localparam logic [8:0] ACC_SAT  = 9'd256;
	// Index of the last (blue) component.
	localparam logic [1:0] COMP_LAST = 2'd2;

	// Space, tab, newline, vertical tab, form feed or carriage return.
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgb_decimal_triplet_parser.sv =====
// A terminator request passes through the input stage and then the result register before its result shows.
// Throughput: one input request per cycle unless a terminator waits; bytes in the input stage never wait on the output.
// A terminator waits only while the result register holds an untaken result.
// Reset clears the input stage, the line state, the result register and both
// color valid flags at once; the block is ready right after reset.
// ----------------------------------------------------------------------------
// RGB decimal triplet parser
// Parses "r,g,b" decimal text one byte per request and reports a status and
// the packed color on each end-of-line request.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_decimal_triplet_parser
	import rgbdtp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  wire logic        s_axis_tlast,   // end_of_line
	input  wire logic        s_axis_tuser,   // [0] target
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [1:0] status, [25:2] rgb, rest zero
	output logic             m_axis_tuser    // [0] target_echo
);

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_DIGITS,
		PH_AFTER,
		PH_ERR
	} phase_t;

	// Input stage.
	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        eol_s1;
	logic        tgt_s1;

	// Result stage.
	logic        valid_s2;
	status_t     status_s2;
	logic [23:0] rgb_s2;
	logic        tgt_s2;

	// Line state and stored color flags.
	phase_t      phase_q, phase_d;
	logic [1:0]  comp_q, comp_d;
	logic [8:0]  acc_q, acc_d;
	logic [15:0] rg_q, rg_d;
	status_t     err_q, err_d;
	logic        floor_vld_q, floor_vld_d;
	logic        ceil_vld_q, ceil_vld_d;

	logic        out_free;
	logic        adv_s1;
	logic        load_s2;
	logic        ws;
	logic        dig;
	logic [3:0]  digit;
	logic [11:0] acc_x10;
	logic        close_ok;
	logic [15:0] rg_closed;
	logic        comma_ok;
	status_t     res_status;
	logic [23:0] res_rgb;

	// Handshake: bytes always advance, a terminator needs a free result slot.
	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && (!eol_s1 || out_free);
	assign load_s2       = adv_s1 && eol_s1;
	assign s_axis_tready = !valid_s1 || adv_s1;

	// Byte classes and the times-ten accumulate.
	assign ws        = is_ws(ch_s1);
	assign dig       = is_dig(ch_s1);
	assign digit     = ch_s1[3:0];
	assign acc_x10   = ({3'b000, acc_q} << 3) + ({3'b000, acc_q} << 1) + {8'h00, digit};
	assign close_ok  = (acc_q <= COMP_MAX);
	assign comma_ok  = (ch_s1 == CH_COMMA) && (comp_q < COMP_LAST);

	// Value of red and green once the current digit run closes.
	always_comb begin
		rg_closed = rg_q;
		if (comp_q == 2'd0) begin
			rg_closed[15:8] = acc_q[7:0];
		end else if (comp_q == 2'd1) begin
			rg_closed[7:0] = acc_q[7:0];
		end
	end

	// Next line state and the result of a terminator.
	always_comb begin
		phase_d     = phase_q;
		comp_d      = comp_q;
		acc_d       = acc_q;
		rg_d        = rg_q;
		err_d       = err_q;
		floor_vld_d = floor_vld_q;
		ceil_vld_d  = ceil_vld_q;
		res_status  = ST_OK;
		res_rgb     = '0;
		if (!eol_s1) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (ws) begin
						phase_d = PH_LEAD;
					end else if (dig) begin
						acc_d   = {5'b00000, digit};
						phase_d = PH_DIGITS;
					end else begin
						if (err_q == ST_OK) err_d = ST_VALUE;
						phase_d = PH_ERR;
					end
				end
				PH_DIGITS: begin
					if (dig) begin
						acc_d = (acc_x10 > {3'b000, ACC_SAT}) ? ACC_SAT : acc_x10[8:0];
					end else if (!close_ok) begin
						if (err_q == ST_OK) err_d = ST_VALUE;
						phase_d = PH_ERR;
					end else begin
						rg_d = rg_closed;
						if (ws) begin
							phase_d = PH_AFTER;
						end else if (comma_ok) begin
							comp_d  = comp_q + 2'd1;
							acc_d   = '0;
							phase_d = PH_LEAD;
						end else begin
							if (err_q == ST_OK) err_d = ST_FORMAT;
							phase_d = PH_ERR;
						end
					end
				end
				PH_AFTER: begin
					if (ws) begin
						phase_d = PH_AFTER;
					end else if (comma_ok) begin
						comp_d  = comp_q + 2'd1;
						acc_d   = '0;
						phase_d = PH_LEAD;
					end else begin
						if (err_q == ST_OK) err_d = ST_FORMAT;
						phase_d = PH_ERR;
					end
				end
				PH_ERR: begin
					phase_d = PH_ERR;
				end
				default: begin
					phase_d = PH_ERR;
				end
			endcase
		end else begin
			// End of line: first error wins, then the line shape is checked.
			res_status = err_q;
			if (err_q == ST_OK) begin
				if (phase_q == PH_DIGITS) begin
					if (!close_ok) begin
						res_status = ST_VALUE;
					end else if (comp_q != COMP_LAST) begin
						res_status = ST_FORMAT;
					end
				end else if (phase_q == PH_AFTER) begin
					if (comp_q != COMP_LAST) res_status = ST_FORMAT;
				end else begin
					res_status = ST_FORMAT;
				end
			end
			// A duplicate outranks every other outcome.
			if (floor_vld_q && ceil_vld_q) res_status = ST_DUP;
			if (res_status == ST_OK) begin
				res_rgb = {rg_q, acc_q[7:0]};
				if (tgt_s1) begin
					ceil_vld_d = 1'b1;
				end else begin
					floor_vld_d = 1'b1;
				end
			end
			phase_d = PH_LEAD;
			comp_d  = '0;
			acc_d   = '0;
			rg_d    = '0;
			err_d   = ST_OK;
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1  <= s_axis_tdata;
			eol_s1 <= s_axis_tlast;
			tgt_s1 <= s_axis_tuser;
		end
	end

	// Line state and stored color flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			comp_q      <= '0;
			acc_q       <= '0;
			rg_q        <= '0;
			err_q       <= ST_OK;
			floor_vld_q <= 1'b0;
			ceil_vld_q  <= 1'b0;
		end else if (adv_s1) begin
			phase_q     <= phase_d;
			comp_q      <= comp_d;
			acc_q       <= acc_d;
			rg_q        <= rg_d;
			err_q       <= err_d;
			floor_vld_q <= floor_vld_d;
			ceil_vld_q  <= ceil_vld_d;
		end
	end

	// Result stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= load_s2;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (load_s2) begin
			status_s2 <= res_status;
			rgb_s2    <= res_rgb;
			tgt_s2    <= tgt_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'b000000, rgb_s2, status_s2};
	assign m_axis_tuser  = tgt_s2;

	// A failing line never carries a color.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (status_s2 != ST_OK)) |-> (rgb_s2 == 24'h000000))
		else $error("rgb nonzero on a failing result");

	// The accumulator saturates and never passes its ceiling.
	assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= ACC_SAT)
		else $error("accumulator above saturation");

	// The error phase is entered only with an error recorded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR) |-> (err_q != ST_OK))
		else $error("error phase without a recorded error");

	// A stored color stays stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		(floor_vld_q && ceil_vld_q) |=> (floor_vld_q && ceil_vld_q))
		else $error("stored color flag dropped");

	// An accepted line for the ceiling target marks the ceiling color as stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && (res_status == ST_OK) && tgt_s1) |=> ceil_vld_q)
		else $error("ceiling not marked after a good line");

	// Terminators only leave the input stage when the result slot is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_axis_tready) |=> (valid_s2 && $stable(status_s2)))
		else $error("untaken result overwritten");

endmodule

`default_nettype wire
